>>> rtl/kmer_pkg.sv
// kmer_pkg: types and constants shared by the key macro event recorder
// modes, error codes, operations, entry kinds, controller commands and status
// no dependencies
package kmer_pkg;

   localparam int REC_COUNT_W = 9;

   localparam logic [31:0] DELAY_MIN_MS   = 32'd10;
   localparam logic [31:0] DELAY_CHUNK_MS = 32'd60000;
   localparam logic [15:0] NO_KEY         = 16'hffff;
   localparam logic [7:0]  MODIFIER_BASE  = 8'he0;
   localparam logic [7:0]  MODIFIER_COUNT = 8'd8;

   localparam logic [7:0] CLASS_KEYBOARD = 8'd0;
   localparam logic [7:0] CLASS_SYSTEM   = 8'd1;
   localparam logic [7:0] CLASS_CONSUMER = 8'd2;

   localparam logic [2:0] KIND_NONE     = 3'd0;
   localparam logic [2:0] KIND_PRESS    = 3'd1;
   localparam logic [2:0] KIND_RELEASE  = 3'd2;
   localparam logic [2:0] KIND_DELAY    = 3'd4;
   localparam logic [2:0] KIND_CONSUMER = 3'd5;
   localparam logic [2:0] KIND_SYSTEM   = 3'd6;

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_CONFIRM = 3'd1,
      MODE_REC     = 3'd2,
      MODE_SAVED   = 3'd3,
      MODE_ERROR   = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      ERR_NONE   = 3'd0,
      ERR_FULL   = 3'd1,
      ERR_NO_ID  = 3'd2,
      ERR_EMPTY  = 3'd3,
      ERR_CANCEL = 3'd4
   } err_type;

   typedef enum logic [2:0] {
      OP_KEY    = 3'd0,
      OP_CLICK  = 3'd1,
      OP_ROTATE = 3'd2,
      OP_LONG   = 3'd3,
      OP_PAGE   = 3'd4,
      OP_READ   = 3'd5
   } op_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  value;
      logic [15:0] param;
   } entry_type;

   typedef struct packed {
      logic [2:0]             mode;
      logic [2:0]             error_code;
      logic                   pass_through;
      logic [REC_COUNT_W-1:0] rec_count;
      logic [2:0]             entry_kind;
      logic [7:0]             entry_value;
      logic [15:0]            entry_param;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic apply_op;
      logic load_gap;
      logic push_delay;
      logic push_key;
      logic fail_full;
      logic read_issue;
      logic latch_entry;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic key_rec;
      logic read_op;
      logic count_zero;
      logic gap_ge_min;
      logic full;
      logic rsp_free;
   } status_type;

endpackage

>>> rtl/kmer_req_if.sv
// kmer_req_if: request channel of the key macro event recorder
// valid/ready handshake with one input item as payload; no dependencies
interface kmer_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  operation;
   logic [15:0] key_code;
   logic        key_pressed;
   logic [31:0] now_ms;
   logic [7:0]  read_index;

   modport source (
      output valid, operation, key_code, key_pressed, now_ms, read_index,
      input  ready
   );
   modport sink (
      input  valid, operation, key_code, key_pressed, now_ms, read_index,
      output ready
   );
endinterface

>>> rtl/kmer_rsp_if.sv
// kmer_rsp_if: response channel of the key macro event recorder
// valid/ready handshake with one result item as payload; no dependencies
interface kmer_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  mode;
   logic [2:0]  error_code;
   logic        pass_through;
   logic [8:0]  rec_count;
   logic [2:0]  entry_kind;
   logic [7:0]  entry_value;
   logic [15:0] entry_param;

   modport source (
      output valid, mode, error_code, pass_through, rec_count,
             entry_kind, entry_value, entry_param,
      input  ready
   );
   modport sink (
      input  valid, mode, error_code, pass_through, rec_count,
             entry_kind, entry_value, entry_param,
      output ready
   );
endinterface

>>> rtl/key_macro_event_recorder.sv
// key_macro_event_recorder: records keyboard macros into an action buffer
// depends on kmer_pkg, kmer_req_if, kmer_rsp_if, kmer_ctrl, kmer_dpath, kmer_ram
//
// usage
//   req_ch carries one operation per item: key event, wheel click, wheel
//   rotate, long press, page enter or read entry. every item gives exactly
//   one rsp_ch item with the mode, error code, pass-through choice, action
//   count and, for a read, the buffer entry.
//   csr_we/csr_wdata write the next macro id; the user must do so only while
//   no item is in flight, as the block itself does not enforce this. one
//   item is worked on at a time. after acceptance the sequencer steps through
//   exec and done for a plain operation, with a read step between for a read
//   (registered buffer read) and a key step for the first key of a recording;
//   a later key event while recording writes its delay chunks, if any, one
//   buffer entry per cycle, at most MAX_ACTIONS chunks, then its key. the next
//   item is accepted in the cycle after the response loads. the response sits
//   in an output register, so the next item is accepted and worked on while
//   rsp_ch stalls; the block then holds its finished result until the slot frees.
//   reset (synchronous) leaves the recorder idle with an empty buffer and
//   next macro id 1; buffer contents are not cleared and not needed.
module key_macro_event_recorder import kmer_pkg::*; #(
   parameter int MAX_ACTIONS = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata,
   kmer_req_if.sink   req_ch,
   kmer_rsp_if.source rsp_ch
);
   cmd_type    cmd;
   status_type status;
   logic       req_ready;
   logic       rsp_valid;
   rsp_type    rsp_data;

   kmer_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   kmer_dpath #(
      .MAX_ACTIONS (MAX_ACTIONS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .operation   (req_ch.operation),
      .key_code    (req_ch.key_code),
      .key_pressed (req_ch.key_pressed),
      .now_ms      (req_ch.now_ms),
      .read_index  (req_ch.read_index),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ch.ready),
      .rsp_data    (rsp_data)
   );

   assign req_ch.ready        = req_ready;
   assign rsp_ch.valid        = rsp_valid;
   assign rsp_ch.mode         = rsp_data.mode;
   assign rsp_ch.error_code   = rsp_data.error_code;
   assign rsp_ch.pass_through = rsp_data.pass_through;
   assign rsp_ch.rec_count    = rsp_data.rec_count;
   assign rsp_ch.entry_kind   = rsp_data.entry_kind;
   assign rsp_ch.entry_value  = rsp_data.entry_value;
   assign rsp_ch.entry_param  = rsp_data.entry_param;
endmodule

>>> rtl/kmer_ram.sv
// kmer_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module kmer_ram #(
   parameter int WIDTH = 27,
   parameter int DEPTH = 256,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

>>> rtl/kmer_ctrl.sv
// kmer_ctrl: sequencer of the key macro event recorder
// steps each item through decode, then as needed delay chunks, key append or read, and output
// depends on kmer_pkg
module kmer_ctrl import kmer_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);
   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_DELAY,
      S_KEY,
      S_READ,
      S_DONE
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            priority if (status.key_rec) begin
               if (status.count_zero) begin
                  state_in = S_KEY;
               end else begin
                  cmd.load_gap = 1'b1;
                  state_in     = S_DELAY;
               end
            end else if (status.read_op) begin
               cmd.read_issue = 1'b1;
               state_in       = S_READ;
            end else begin
               cmd.apply_op = 1'b1;
               state_in     = S_DONE;
            end
         end
         S_DELAY: begin
            priority if (!status.gap_ge_min) begin
               state_in = S_KEY;
            end else if (status.full) begin
               cmd.fail_full = 1'b1;
               state_in      = S_DONE;
            end else begin
               cmd.push_delay = 1'b1;
            end
         end
         S_KEY: begin
            if (status.full) begin
               cmd.fail_full = 1'b1;
            end else begin
               cmd.push_key = 1'b1;
            end
            state_in = S_DONE;
         end
         S_READ: begin
            cmd.latch_entry = 1'b1;
            state_in        = S_DONE;
         end
         S_DONE: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

>>> rtl/kmer_dpath.sv
// kmer_dpath: mode registers, delay gap unit, action buffer and output register
// depends on kmer_pkg and kmer_ram
module kmer_dpath import kmer_pkg::*; #(
   parameter int MAX_ACTIONS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata,
   input  logic [2:0]  operation,
   input  logic [15:0] key_code,
   input  logic        key_pressed,
   input  logic [31:0] now_ms,
   input  logic [7:0]  read_index,
   input  cmd_type     cmd,
   output status_type  status,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data
);
   localparam int CW = $clog2(MAX_ACTIONS + 1);
   localparam int AW = (MAX_ACTIONS > 1) ? $clog2(MAX_ACTIONS) : 1;

   // registers
   logic [7:0]    next_id_ff;
   mode_type      mode_ff, mode_in;
   err_type       err_ff, err_in;
   logic          pass_ff, pass_in;
   logic [CW-1:0] count_ff, count_in;
   logic [31:0]   last_ff, last_in;
   logic [31:0]   gap_ff, gap_in;
   op_type        op_ff;
   logic [15:0]   code_ff;
   logic          pressed_ff;
   logic [31:0]   now_ff;
   logic [7:0]    idx_ff;
   entry_type     entry_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff;

   // decode and datapath wires
   logic [7:0]             key_class, key_val;
   logic [2:0]             key_kind;
   logic [7:0]             key_usage;
   logic                   key_ok;
   logic                   no_id;
   mode_type               pe_mode;
   err_type                pe_err;
   logic [15:0]            part;
   logic                   full;
   logic [CW+7:0]          idx_wide, cnt_wide;
   logic [CW+REC_COUNT_W-1:0] cnt_out;
   logic                   ram_we;
   entry_type              ram_wdata, ram_rdata;

   assign key_class = code_ff[15:8];
   assign key_val   = code_ff[7:0];

   always_comb begin
      key_kind  = KIND_NONE;
      key_usage = key_val;
      key_ok    = 1'b0;
      priority if (key_class == CLASS_KEYBOARD) begin
         key_ok    = 1'b1;
         key_kind  = pressed_ff ? KIND_PRESS : KIND_RELEASE;
         key_usage = (key_val >= MODIFIER_COUNT) ? key_val - MODIFIER_COUNT
                                                 : MODIFIER_BASE + key_val;
      end else if (pressed_ff && key_class == CLASS_CONSUMER) begin
         key_ok   = 1'b1;
         key_kind = KIND_CONSUMER;
      end else if (pressed_ff && key_class == CLASS_SYSTEM) begin
         key_ok   = 1'b1;
         key_kind = KIND_SYSTEM;
      end else begin
         key_ok = 1'b0;
      end
   end

   assign no_id   = (next_id_ff == 8'd0);
   assign pe_mode = no_id ? MODE_ERROR : MODE_IDLE;
   assign pe_err  = no_id ? ERR_NO_ID : ERR_NONE;
   assign full    = (count_ff >= CW'(MAX_ACTIONS));
   assign part    = (gap_ff > DELAY_CHUNK_MS) ? DELAY_CHUNK_MS[15:0] : gap_ff[15:0];

   assign idx_wide = {{CW{1'b0}}, idx_ff};
   assign cnt_wide = {8'd0, count_ff};
   assign cnt_out  = {{REC_COUNT_W{1'b0}}, count_ff};

   assign status.key_rec    = (op_ff == OP_KEY) && (mode_ff == MODE_REC) &&
                              (code_ff != NO_KEY) && key_ok;
   assign status.read_op    = (op_ff == OP_READ);
   assign status.count_zero = (count_ff == '0);
   assign status.gap_ge_min = (gap_ff >= DELAY_MIN_MS);
   assign status.full       = full;
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

   // mode machine and counters
   always_comb begin
      mode_in  = mode_ff;
      err_in   = err_ff;
      pass_in  = pass_ff;
      count_in = count_ff;
      last_in  = last_ff;
      gap_in   = gap_ff;
      if (cmd.apply_op) begin
         unique case (op_ff)
            OP_CLICK: begin
               unique case (mode_ff)
                  MODE_IDLE: begin
                     pass_in = 1'b0;
                     mode_in = MODE_CONFIRM;
                  end
                  MODE_CONFIRM: begin
                     if (no_id) begin
                        mode_in = MODE_ERROR;
                        err_in  = ERR_NO_ID;
                     end else begin
                        count_in = '0;
                        last_in  = now_ff;
                        err_in   = ERR_NONE;
                        mode_in  = MODE_REC;
                     end
                  end
                  MODE_REC: begin
                     if (count_ff == '0) begin
                        mode_in = MODE_ERROR;
                        err_in  = ERR_EMPTY;
                     end else begin
                        mode_in = MODE_SAVED;
                     end
                  end
                  default: begin
                     pass_in = 1'b0;
                     mode_in = pe_mode;
                     err_in  = pe_err;
                  end
               endcase
            end
            OP_ROTATE: begin
               if (mode_ff == MODE_CONFIRM) begin
                  pass_in = ~pass_ff;
               end
            end
            OP_LONG: begin
               priority if (mode_ff == MODE_CONFIRM || mode_ff == MODE_ERROR ||
                            mode_ff == MODE_SAVED) begin
                  pass_in = 1'b0;
                  mode_in = pe_mode;
                  err_in  = pe_err;
               end else if (mode_ff == MODE_REC) begin
                  mode_in = MODE_ERROR;
                  err_in  = ERR_CANCEL;
               end else begin
                  mode_in = mode_ff;
               end
            end
            OP_PAGE: begin
               if (mode_ff != MODE_REC) begin
                  pass_in = 1'b0;
                  mode_in = pe_mode;
                  err_in  = pe_err;
               end
            end
            default: begin
               mode_in = mode_ff;
            end
         endcase
      end
      if (cmd.load_gap) begin
         gap_in = now_ff - last_ff;
      end
      if (cmd.push_delay) begin
         gap_in   = gap_ff - {16'd0, part};
         count_in = count_ff + 1'b1;
      end
      if (cmd.push_key) begin
         count_in = count_ff + 1'b1;
         last_in  = now_ff;
      end
      if (cmd.fail_full) begin
         mode_in = MODE_ERROR;
         err_in  = ERR_FULL;
      end
   end

   // action buffer
   assign ram_we = cmd.push_delay || cmd.push_key;
   always_comb begin
      if (cmd.push_delay) begin
         ram_wdata = '{kind: KIND_DELAY, value: 8'd0, param: part};
      end else begin
         ram_wdata = '{kind: key_kind, value: key_usage, param: 16'd0};
      end
   end

   kmer_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (MAX_ACTIONS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (count_ff[AW-1:0]),
      .wdata (ram_wdata),
      .re    (cmd.read_issue),
      .raddr (idx_wide[AW-1:0]),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         next_id_ff   <= 8'd1;
         mode_ff      <= MODE_IDLE;
         err_ff       <= ERR_NONE;
         pass_ff      <= 1'b0;
         count_ff     <= '0;
         last_ff      <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            next_id_ff <= csr_wdata;
         end
         mode_ff      <= mode_in;
         err_ff       <= err_in;
         pass_ff      <= pass_in;
         count_ff     <= count_in;
         last_ff      <= last_in;
         rsp_valid_ff <= cmd.load_rsp ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      end
   end

   // item capture, gap and output payload
   always_ff @(posedge clock) begin
      gap_ff <= gap_in;
      if (cmd.capture) begin
         op_ff      <= op_type'(operation);
         code_ff    <= key_code;
         pressed_ff <= key_pressed;
         now_ff     <= now_ms;
         idx_ff     <= read_index;
         entry_ff   <= '0;
      end else if (cmd.latch_entry) begin
         entry_ff <= (idx_wide < cnt_wide) ? ram_rdata : '0;
      end
      if (cmd.load_rsp) begin
         rsp_ff.mode         <= mode_ff;
         rsp_ff.error_code   <= err_ff;
         rsp_ff.pass_through <= pass_ff;
         rsp_ff.rec_count    <= cnt_out[REC_COUNT_W-1:0];
         rsp_ff.entry_kind   <= entry_ff.kind;
         rsp_ff.entry_value  <= entry_ff.value;
         rsp_ff.entry_param  <= entry_ff.param;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ACTIONS))
      else $error("action count beyond buffer depth");

   a_error_code: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_ERROR) == (err_ff != ERR_NONE))
      else $error("error mode and error code disagree");

   a_rsp_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("response loaded over a pending item");

   a_append: assert property (@(posedge clock) disable iff (reset)
      (cmd.push_delay || cmd.push_key) |=> count_ff == CW'($past(count_ff) + 1'b1))
      else $error("append did not advance the count");

   a_delay_gap: assert property (@(posedge clock) disable iff (reset)
      cmd.push_delay |-> (gap_ff >= DELAY_MIN_MS && mode_ff == MODE_REC))
      else $error("delay appended outside recording or below minimum");
endmodule
